// File: hdl/css_pkg.sv
// ----------------------------------------------------------------------------
// css_pkg
// Shared widths, queue depth and a clog2 helper for the streaming cosine similarity core.
// ----------------------------------------------------------------------------
package css_pkg;

    localparam int DEF_MAX_ELEMENTS = 4096;
    localparam int DEF_SAMPLE_BITS  = 16;
    localparam int ELEM_W = 16;
    localparam int SIM_W  = 16;
    localparam int QDEPTH = 2;

    function automatic int clog2c(input int v);
        int r;
        r = 0;
        while ((1 << r) < v) r = r + 1;
        return r;
    endfunction

endpackage

// File: hdl/css_front.sv
// ----------------------------------------------------------------------------
// css_front
// Accumulates dot product and squared norms; posts finished vector sums.
// ----------------------------------------------------------------------------
module css_front
    import css_pkg::*;
#(
    parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
    parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS,
    parameter int CNT_W  = clog2c(MAX_ELEMENTS + 1),
    parameter int NORM_W = 2 * SAMPLE_BITS - 2 + clog2c(MAX_ELEMENTS + 1),
    parameter int DOT_W  = NORM_W + 1
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [ELEM_W-1:0] elem_a,
    input  logic signed [ELEM_W-1:0] elem_b,
    input  logic                     last_element,
    output logic                     q_valid,
    input  logic                     q_ready,
    output logic signed [DOT_W-1:0]  q_dot,
    output logic [NORM_W-1:0]        q_na,
    output logic [NORM_W-1:0]        q_nb,
    output logic                     q_ovf
);

    localparam int PW = 2 * SAMPLE_BITS;

    logic signed [DOT_W-1:0] dot_reg;
    logic [NORM_W-1:0]       na_reg, nb_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    ovf_reg;

    logic signed [DOT_W-1:0] dq_reg [QDEPTH];
    logic [NORM_W-1:0]       aq_reg [QDEPTH];
    logic [NORM_W-1:0]       bq_reg [QDEPTH];
    logic                    oq_reg [QDEPTH];
    logic                    wp_reg, rp_reg;
    logic [1:0]              fill_reg;

    logic signed [SAMPLE_BITS-1:0] sa, sb;
    logic signed [PW-1:0]          pab, paa, pbb;
    logic                          take, acc_ok, push, pop;
    logic signed [DOT_W-1:0]       dot_next;
    logic [NORM_W-1:0]             na_next, nb_next;
    logic                          ovf_next;

    assign sa = elem_a[SAMPLE_BITS-1:0];
    assign sb = elem_b[SAMPLE_BITS-1:0];
    assign pab = sa * sb;
    assign paa = sa * sa;
    assign pbb = sb * sb;

    assign in_ready = (fill_reg != 2'(QDEPTH)) || !last_element;
    assign take     = in_valid && in_ready;
    assign push     = take && last_element;
    assign pop      = q_valid && q_ready;
    assign acc_ok   = cnt_reg < CNT_W'(MAX_ELEMENTS);

    always_comb
    begin
        dot_next = dot_reg;
        na_next  = na_reg;
        nb_next  = nb_reg;
        ovf_next = ovf_reg;
        if (acc_ok)
        begin
            dot_next = dot_reg + DOT_W'(pab);
            na_next  = na_reg + NORM_W'($unsigned(paa));
            nb_next  = nb_reg + NORM_W'($unsigned(pbb));
        end
        else
            ovf_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg  <= '0;
            na_reg   <= '0;
            nb_reg   <= '0;
            cnt_reg  <= '0;
            ovf_reg  <= 1'b0;
            wp_reg   <= 1'b0;
            rp_reg   <= 1'b0;
            fill_reg <= '0;
        end
        else
        begin
            if (take)
            begin
                if (last_element)
                begin
                    dot_reg <= '0;
                    na_reg  <= '0;
                    nb_reg  <= '0;
                    cnt_reg <= '0;
                    ovf_reg <= 1'b0;
                end
                else
                begin
                    dot_reg <= dot_next;
                    na_reg  <= na_next;
                    nb_reg  <= nb_next;
                    ovf_reg <= ovf_next;
                    if (acc_ok)
                        cnt_reg <= cnt_reg + 1'b1;
                end
            end
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            if (push && !pop)
                fill_reg <= fill_reg + 1'b1;
            else if (pop && !push)
                fill_reg <= fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            dq_reg[wp_reg] <= dot_next;
            aq_reg[wp_reg] <= na_next;
            bq_reg[wp_reg] <= nb_next;
            oq_reg[wp_reg] <= ovf_next;
        end
    end

    assign q_valid = fill_reg != '0;
    assign q_dot   = dq_reg[rp_reg];
    assign q_na    = aq_reg[rp_reg];
    assign q_nb    = bq_reg[rp_reg];
    assign q_ovf   = oq_reg[rp_reg];

    a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= 2'(QDEPTH)) else $error("queue overfill");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == 2'(QDEPTH)) |-> !push) else $error("push into full queue");
    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_ELEMENTS)) else $error("count overrun");

endmodule

// File: hdl/css_back.sv
// ----------------------------------------------------------------------------
// css_back
// Norm product, bit-serial square root and restoring divide per vector.
// ----------------------------------------------------------------------------
module css_back
    import css_pkg::*;
#(
    parameter int NORM_W = 42,
    parameter int DOT_W  = 43
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_valid,
    output logic                    q_ready,
    input  logic signed [DOT_W-1:0] q_dot,
    input  logic [NORM_W-1:0]       q_na,
    input  logic [NORM_W-1:0]       q_nb,
    input  logic                    q_ovf,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [SIM_W-1:0]        similarity,
    output logic                    zero_norm,
    output logic                    too_long
);

    localparam int HW   = (NORM_W + 1) / 2;
    localparam int PRW  = 2 * NORM_W;
    localparam int RW   = NORM_W;
    localparam int PPW  = 2 * HW;
    localparam int RRW  = RW + 2;
    localparam int SW   = clog2c(RW + 1);

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_SQRT, S_CMP, S_DIV, S_OUT} state_t;

    state_t               st_reg;
    logic [HW-1:0]        ah_reg, al_reg, bh_reg, bl_reg;
    logic [1:0]           pp_reg;
    logic [PRW-1:0]       prod_reg;
    logic [PPW-1:0]       ppart_reg;
    logic [RRW-1:0]       rem_reg;
    logic [RW-1:0]        root_reg;
    logic [SW-1:0]        step_reg;
    logic [DOT_W-1:0]     mag_reg;
    logic                 neg_reg, ovf_reg;
    logic [SIM_W-1:0]     q_reg;
    logic [DOT_W:0]       r_reg;
    logic [SIM_W-1:0]     sim_reg;
    logic                 zn_reg, tl_reg, ov_reg;

    logic [HW-1:0]        mx, my;
    logic [RRW-1:0]       rem_sh, trial;
    logic [DOT_W:0]       r_sh;

    always_comb
    begin
        case (pp_reg)
            2'd0:    begin mx = al_reg; my = bl_reg; end
            2'd1:    begin mx = al_reg; my = bh_reg; end
            2'd2:    begin mx = ah_reg; my = bl_reg; end
            default: begin mx = ah_reg; my = bh_reg; end
        endcase
    end

    // digit-by-digit root: two product bits per step
    assign rem_sh = {rem_reg[RRW-3:0], prod_reg[PRW-1 -: 2]};
    assign trial  = {root_reg, 2'b01};
    assign r_sh   = {r_reg[DOT_W-1:0], 1'b0};

    // result register must be empty before the next vector is taken
    assign q_ready   = (st_reg == S_IDLE) && !ov_reg;
    assign out_valid = ov_reg;
    assign similarity = sim_reg;
    assign zero_norm  = zn_reg;
    assign too_long   = tl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (ov_reg && out_ready)
                ov_reg <= 1'b0;
            unique case (st_reg)
                S_IDLE:
                begin
                    if (q_valid && q_ready)
                    begin
                        ah_reg  <= HW'((PPW)'(q_na) >> HW);
                        al_reg  <= q_na[HW-1:0];
                        bh_reg  <= HW'((PPW)'(q_nb) >> HW);
                        bl_reg  <= q_nb[HW-1:0];
                        neg_reg <= q_dot[DOT_W-1];
                        mag_reg <= q_dot[DOT_W-1] ? DOT_W'(-q_dot) : DOT_W'(q_dot);
                        ovf_reg <= q_ovf;
                        prod_reg <= '0;
                        pp_reg  <= '0;
                        if (q_na == '0 || q_nb == '0)
                        begin
                            sim_reg <= '0;
                            zn_reg  <= 1'b1;
                            tl_reg  <= q_ovf;
                            st_reg  <= S_OUT;
                        end
                        else
                            st_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    ppart_reg <= PPW'(mx) * PPW'(my);
                    pp_reg    <= pp_reg + 1'b1;
                    if (pp_reg != 2'd0)
                    begin
                        case (pp_reg)
                            2'd1:    prod_reg <= prod_reg + PRW'(ppart_reg);
                            2'd2:    prod_reg <= prod_reg + (PRW'(ppart_reg) << HW);
                            default: prod_reg <= prod_reg + (PRW'(ppart_reg) << HW);
                        endcase
                    end
                    if (pp_reg == 2'd3)
                        st_reg <= S_CMP;
                end
                S_CMP:
                begin
                    prod_reg <= prod_reg + (PRW'(ppart_reg) << (2 * HW));
                    rem_reg  <= '0;
                    root_reg <= '0;
                    step_reg <= '0;
                    st_reg   <= S_SQRT;
                end
                S_SQRT:
                begin
                    prod_reg <= prod_reg << 2;
                    if (rem_sh >= trial)
                    begin
                        rem_reg  <= rem_sh - trial;
                        root_reg <= {root_reg[RW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= rem_sh;
                        root_reg <= {root_reg[RW-2:0], 1'b0};
                    end
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == SW'(RW - 1))
                    begin
                        r_reg  <= (DOT_W + 1)'(mag_reg);
                        q_reg  <= '0;
                        pp_reg <= '0;
                        st_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (step_reg == SW'(RW))
                    begin
                        if ((DOT_W + 1)'(mag_reg) >= (DOT_W + 1)'(root_reg))
                        begin
                            q_reg    <= {1'b1, {(SIM_W-1){1'b0}}};
                            step_reg <= SW'(RW + 16);
                        end
                        else
                            step_reg <= step_reg + 1'b1;
                    end
                    else if (step_reg == SW'(RW + 16))
                    begin
                        sim_reg <= neg_reg
                            ? (q_reg[SIM_W-1] ? {1'b1, {(SIM_W-1){1'b0}}} : SIM_W'(-q_reg))
                            : (q_reg >= 16'h7fff ? 16'h7fff : q_reg);
                        zn_reg  <= 1'b0;
                        tl_reg  <= ovf_reg;
                        st_reg  <= S_OUT;
                    end
                    else
                    begin
                        if (r_sh >= (DOT_W + 1)'(root_reg))
                        begin
                            r_reg <= r_sh - (DOT_W + 1)'(root_reg);
                            q_reg <= {q_reg[SIM_W-2:0], 1'b1};
                        end
                        else
                        begin
                            r_reg <= r_sh;
                            q_reg <= {q_reg[SIM_W-2:0], 1'b0};
                        end
                        step_reg <= step_reg + 1'b1;
                    end
                end
                S_OUT:
                begin
                    if (!ov_reg || out_ready)
                    begin
                        ov_reg <= 1'b1;
                        st_reg <= S_IDLE;
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(similarity))
        else $error("result dropped");
    a_zero_val: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && zero_norm) |-> similarity == '0) else $error("zero norm value");
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_ready |-> st_reg == S_IDLE) else $error("take while busy");

endmodule

// File: hdl/cosine_similarity_stream_core.sv
// ----------------------------------------------------------------------------
// cosine_similarity_stream_core
// Streaming cosine similarity of two Q1.15 vectors.
// ----------------------------------------------------------------------------
// Slave channel: one element pair per transfer, tlast marks the final pair.
// The front accumulates at one transfer per cycle unless a tlast stalls. On
// tlast the exact sums go into a two-entry queue and the sums clear, so the
// next vector streams at once. The back forms the norm product (four 22x22
// partial products), a bit-serial root (one bit per cycle, NORM_W bits, 43
// at defaults) and a restoring divide (15 quotient bits); the divide is
// skipped when the quotient clamps, and a zero norm goes straight to the
// result. The back takes the next vector once its result has gone.
// A vector that arrives faster than the back finishes stalls s_axis_tready
// on its tlast once the queue holds two vectors.
// Master channel: one result per vector; tdata holds the similarity, tuser
// holds zero_norm then too_long. A stalled receiver holds the result and the
// back stops, the queue then fills and the slave side stalls on tlast.
// Reset clears the sums, the queue and the result valid flag.
// ----------------------------------------------------------------------------
module cosine_similarity_stream_core
    import css_pkg::*;
#(
    parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
    parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // elem_a[15:0], elem_b[31:16]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // similarity
    output logic [1:0]  m_axis_tuser    // zero_norm, too_long
);

    localparam int NORM_W = 2 * SAMPLE_BITS - 2 + clog2c(MAX_ELEMENTS + 1);
    localparam int DOT_W  = NORM_W + 1;

    logic                    q_valid, q_ready, q_ovf;
    logic signed [DOT_W-1:0] q_dot;
    logic [NORM_W-1:0]       q_na, q_nb;

    css_front #(
        .MAX_ELEMENTS(MAX_ELEMENTS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .NORM_W      (NORM_W),
        .DOT_W       (DOT_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .elem_a      (s_axis_tdata[15:0]),
        .elem_b      (s_axis_tdata[31:16]),
        .last_element(s_axis_tlast),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_dot       (q_dot),
        .q_na        (q_na),
        .q_nb        (q_nb),
        .q_ovf       (q_ovf)
    );

    css_back #(
        .NORM_W(NORM_W),
        .DOT_W (DOT_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_dot     (q_dot),
        .q_na      (q_na),
        .q_nb      (q_nb),
        .q_ovf     (q_ovf),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .similarity(m_axis_tdata),
        .zero_norm (m_axis_tuser[0]),
        .too_long  (m_axis_tuser[1])
    );

endmodule

// File: tb/sv/cosine_similarity_stream_core_tb.sv
// ----------------------------------------------------------------------------
// cosine_similarity_stream_core_tb
// Streams element pairs into the core and checks every similarity result
// against a local bit-accurate predictor. The stimulus is a short directed
// set of vectors, then random vectors. Both sides stall at random.
// ----------------------------------------------------------------------------
module cosine_similarity_stream_core_tb;
    import css_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PAIRS = DEF_MAX_ELEMENTS;

    typedef struct {
        logic signed [15:0] a;
        logic signed [15:0] b;
        bit                 last;
    } pair_t;

    typedef struct {
        logic [15:0] sim;
        bit          zn;
        bit          tl;
    } cos_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    pair_t       pending_pairs[$];
    cos_result_t expected_cos[$];
    int          errors;
    bit          quiet_src;
    bit          quiet_sink;

    // running sums of the vector being streamed
    logic signed [63:0] dot_acc;
    logic [63:0]        norm_a_acc;
    logic [63:0]        norm_b_acc;
    int                 pairs_taken;
    bit                 dropped;

    cosine_similarity_stream_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [63:0] floor_root(input logic [127:0] v);
        logic [63:0]  r;
        logic [63:0]  c;
        logic [127:0] sq;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            c = r | (64'd1 << i);
            sq = {64'd0, c} * {64'd0, c};
            if (sq <= v)
                r = c;
        end
        return r;
    endfunction

    // fold one accepted pair into the sums; queue a result on the last pair
    task automatic accumulate_pair(input pair_t p);
        cos_result_t  res;
        logic [127:0] prod;
        logic [63:0]  root;
        logic [63:0]  mag;
        logic [63:0]  rem;
        logic [63:0]  q;
        bit           neg;
        if (pairs_taken < MAX_PAIRS)
        begin
            dot_acc    = dot_acc + 64'(p.a) * 64'(p.b);
            norm_a_acc = norm_a_acc + 64'(64'(p.a) * 64'(p.a));
            norm_b_acc = norm_b_acc + 64'(64'(p.b) * 64'(p.b));
            pairs_taken++;
        end
        else
            dropped = 1'b1;
        if (!p.last)
            return;
        res.sim = '0;
        res.zn  = 1'b0;
        res.tl  = dropped;
        if (norm_a_acc == 0 || norm_b_acc == 0)
            res.zn = 1'b1;
        else
        begin
            neg  = dot_acc < 0;
            prod = {64'd0, norm_a_acc} * {64'd0, norm_b_acc};
            root = floor_root(prod);
            mag  = neg ? -dot_acc : dot_acc;
            if (mag >= root)
                q = 64'd32768;
            else
            begin
                rem = mag;
                q = 0;
                for (int i = 0; i < 15; i++)
                begin
                    rem = rem << 1;
                    q = q << 1;
                    if (rem >= root)
                    begin
                        rem = rem - root;
                        q = q | 64'd1;
                    end
                end
            end
            if (neg)
                res.sim = (q >= 32768) ? 16'h8000 : 16'(-q);
            else
                res.sim = (q >= 32767) ? 16'h7fff : 16'(q);
        end
        expected_cos.push_back(res);
        dot_acc     = '0;
        norm_a_acc  = '0;
        norm_b_acc  = '0;
        pairs_taken = 0;
        dropped     = 1'b0;
    endtask

    function automatic int draw_wait(input bit quiet);
        if (quiet)
            return 0;
        return $urandom_range(0, 13);
    endfunction

    task automatic add_vector(input int len, input int mode);
        pair_t p;
        for (int i = 0; i < len; i++)
        begin
            p.a = $urandom;
            p.b = $urandom;
            case (mode)
                1: p.a = '0;
                2: p.b = '0;
                3: p.b = p.a;
                4: p.b = -p.a;
                5: begin p.a = 16'sh8000; p.b = 16'sh8000; end
                6: begin p.a = 16'sh7fff; p.b = 16'sh8000; end
                7: begin p.a = $urandom_range(0, 3) - 2; p.b = $urandom_range(0, 3) - 2; end
                default: ;
            endcase
            p.last = (i == len - 1);
            pending_pairs.push_back(p);
        end
    endtask

    // driver
    int src_gap;
    pair_t cur_pair;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
            src_gap = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                accumulate_pair(cur_pair);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if ($urandom_range(0, 199) == 0)
                    quiet_src = !quiet_src;
                if (src_gap > 0)
                begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_pairs.size() > 0)
                begin
                    cur_pair = pending_pairs.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {cur_pair.b, cur_pair.a};
                    s_axis_tlast  <= cur_pair.last;
                    src_gap = draw_wait(quiet_src);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor and receiver stalls
    int sink_gap;
    cos_result_t want;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            sink_gap = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_cos.size() == 0)
                begin
                    $error("unexpected transfer: similarity %0d", $signed(m_axis_tdata));
                    errors++;
                end
                else
                begin
                    want = expected_cos.pop_front();
                    if (m_axis_tdata !== want.sim)
                    begin
                        $error("similarity: expected %0d, actual %0d",
                               $signed(want.sim), $signed(m_axis_tdata));
                        errors++;
                    end
                    if (m_axis_tuser[0] !== want.zn)
                    begin
                        $error("zero_norm: expected %0b, actual %0b", want.zn, m_axis_tuser[0]);
                        errors++;
                    end
                    if (m_axis_tuser[1] !== want.tl)
                    begin
                        $error("too_long: expected %0b, actual %0b", want.tl, m_axis_tuser[1]);
                        errors++;
                    end
                end
                sink_gap = draw_wait(quiet_sink);
            end
            if ($urandom_range(0, 199) == 0)
                quiet_sink = !quiet_sink;
            if (sink_gap > 0)
            begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        int total;
        int len;
        errors      = 0;
        quiet_src   = 1'b0;
        quiet_sink  = 1'b0;
        dot_acc     = '0;
        norm_a_acc  = '0;
        norm_b_acc  = '0;
        pairs_taken = 0;
        dropped     = 1'b0;
        rst_n = 1'b0;

        // directed vectors
        add_vector(1, 0);
        add_vector(3, 1);
        add_vector(2, 2);
        add_vector(4, 3);
        add_vector(3, 4);
        add_vector(1, 5);
        add_vector(2, 6);
        add_vector(4, 7);
        add_vector(1, 1);
        add_vector(2, 0);

        // random vectors, mostly short
        total = 0;
        while (total < 430)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 12);
            add_vector(len, $urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 7));
            total += len;
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_pairs.size() == 0 && !s_axis_tvalid && expected_cos.size() == 0);
        repeat (200) @(posedge clk);
        if (errors == 0 && expected_cos.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: sim.f
hdl/css_pkg.sv
hdl/css_front.sv
hdl/css_back.sv
hdl/cosine_similarity_stream_core.sv
tb/sv/cosine_similarity_stream_core_tb.sv
